### rtl/core/fpcd_pkg.sv
package fpcd_pkg;

    localparam int FRAME_BYTES = 15;
    localparam int CRC_BYTES   = 12;
    localparam int SEQ_HI_POS  = 2;
    localparam int CRC_POS     = FRAME_BYTES - 1;
    localparam int FILL_W      = 4;
    localparam int ROT_W       = 4;
    localparam int TDATA_W     = 112;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [7:0] PREAMBLE_FIRST_RST  = 8'h13;
    localparam logic [7:0] PREAMBLE_SECOND_RST = 8'h37;
    localparam logic [7:0] CRC_INIT            = 8'h00;

    localparam logic [CFG_ADDR_W-1:0] REG_PREAMBLE_FIRST  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_PREAMBLE_SECOND = 1'b1;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);
    localparam logic [FILL_W-1:0] FILL_DROP = FILL_W'(FRAME_BYTES - 1);
    localparam logic [ROT_W-1:0]  ROT_LAST  = ROT_W'(FRAME_BYTES - 1);
    localparam logic [ROT_W-1:0]  CRC_STEPS = ROT_W'(CRC_BYTES);

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CRC,
        ST_DONE
    } state_t;

    localparam logic [7:0] CRC_LUT [256] = '{
        8'hea, 8'hd4, 8'h96, 8'ha8, 8'h12, 8'h2c, 8'h6e, 8'h50,
        8'h7f, 8'h41, 8'h03, 8'h3d, 8'h87, 8'hb9, 8'hfb, 8'hc5,
        8'ha5, 8'h9b, 8'hd9, 8'he7, 8'h5d, 8'h63, 8'h21, 8'h1f,
        8'h30, 8'h0e, 8'h4c, 8'h72, 8'hc8, 8'hf6, 8'hb4, 8'h8a,
        8'h74, 8'h4a, 8'h08, 8'h36, 8'h8c, 8'hb2, 8'hf0, 8'hce,
        8'he1, 8'hdf, 8'h9d, 8'ha3, 8'h19, 8'h27, 8'h65, 8'h5b,
        8'h3b, 8'h05, 8'h47, 8'h79, 8'hc3, 8'hfd, 8'hbf, 8'h81,
        8'hae, 8'h90, 8'hd2, 8'hec, 8'h56, 8'h68, 8'h2a, 8'h14,
        8'hb3, 8'h8d, 8'hcf, 8'hf1, 8'h4b, 8'h75, 8'h37, 8'h09,
        8'h26, 8'h18, 8'h5a, 8'h64, 8'hde, 8'he0, 8'ha2, 8'h9c,
        8'hfc, 8'hc2, 8'h80, 8'hbe, 8'h04, 8'h3a, 8'h78, 8'h46,
        8'h69, 8'h57, 8'h15, 8'h2b, 8'h91, 8'haf, 8'hed, 8'hd3,
        8'h2d, 8'h13, 8'h51, 8'h6f, 8'hd5, 8'heb, 8'ha9, 8'h97,
        8'hb8, 8'h86, 8'hc4, 8'hfa, 8'h40, 8'h7e, 8'h3c, 8'h02,
        8'h62, 8'h5c, 8'h1e, 8'h20, 8'h9a, 8'ha4, 8'he6, 8'hd8,
        8'hf7, 8'hc9, 8'h8b, 8'hb5, 8'h0f, 8'h31, 8'h73, 8'h4d,
        8'h58, 8'h66, 8'h24, 8'h1a, 8'ha0, 8'h9e, 8'hdc, 8'he2,
        8'hcd, 8'hf3, 8'hb1, 8'h8f, 8'h35, 8'h0b, 8'h49, 8'h77,
        8'h17, 8'h29, 8'h6b, 8'h55, 8'hef, 8'hd1, 8'h93, 8'had,
        8'h82, 8'hbc, 8'hfe, 8'hc0, 8'h7a, 8'h44, 8'h06, 8'h38,
        8'hc6, 8'hf8, 8'hba, 8'h84, 8'h3e, 8'h00, 8'h42, 8'h7c,
        8'h53, 8'h6d, 8'h2f, 8'h11, 8'hab, 8'h95, 8'hd7, 8'he9,
        8'h89, 8'hb7, 8'hf5, 8'hcb, 8'h71, 8'h4f, 8'h0d, 8'h33,
        8'h1c, 8'h22, 8'h60, 8'h5e, 8'he4, 8'hda, 8'h98, 8'ha6,
        8'h01, 8'h3f, 8'h7d, 8'h43, 8'hf9, 8'hc7, 8'h85, 8'hbb,
        8'h94, 8'haa, 8'he8, 8'hd6, 8'h6c, 8'h52, 8'h10, 8'h2e,
        8'h4e, 8'h70, 8'h32, 8'h0c, 8'hb6, 8'h88, 8'hca, 8'hf4,
        8'hdb, 8'he5, 8'ha7, 8'h99, 8'h23, 8'h1d, 8'h5f, 8'h61,
        8'h9f, 8'ha1, 8'he3, 8'hdd, 8'h67, 8'h59, 8'h1b, 8'h25,
        8'h0a, 8'h34, 8'h76, 8'h48, 8'hf2, 8'hcc, 8'h8e, 8'hb0,
        8'hd0, 8'hee, 8'hac, 8'h92, 8'h28, 8'h16, 8'h54, 8'h6a,
        8'h45, 8'h7b, 8'h39, 8'h07, 8'hbd, 8'h83, 8'hc1, 8'hff
    };

endpackage

### rtl/core/framed_packet_crc8_deframer.sv
// A byte that does not complete the window is taken and the block stays ready for the next byte.
// A byte that completes the window with a wrong preamble holds input off during the check state.
// A byte that completes a frame yields its result after the preamble check state and 15 rotations
// of the byte window, the CRC table applied on the first CRC_BYTES of them; a busy output stalls it.
// Reset (aresetn low, synchronous) empties the window, clears the started flag and the output valid.
module framed_packet_crc8_deframer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fpcd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [7:0]                        cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] rx_byte
    input  logic [7:0]                        s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] sequence_number, [23:16] packet_type, [87:24] body_bytes,
    // [95:88] final_body_byte, [103:96] computed_crc, [111:104] received_crc
    output logic [fpcd_pkg::TDATA_W-1:0]      m_tdata,
    // [0] status
    output logic                              m_tuser
);
    import fpcd_pkg::*;

    state_t               state_reg, state_next;
    logic [7:0]           pre_first_reg, pre_second_reg;
    logic [7:0]           win_reg [FRAME_BYTES];
    logic [7:0]           win_next [FRAME_BYTES];
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic                 started_reg, started_next;
    logic [ROT_W-1:0]     rot_reg, rot_next;
    logic [7:0]           crc_reg, crc_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    logic                 accept;
    logic                 take_byte;
    logic                 preamble_ok;
    logic                 out_free;
    logic                 shift_in;
    logic                 rotate;
    logic                 load_out;
    logic                 crc_match;

    assign accept      = s_tvalid && s_tready;
    assign take_byte   = accept && (started_reg || (s_tdata == pre_first_reg));
    assign preamble_ok = (win_reg[0] == pre_first_reg) && (win_reg[1] == pre_second_reg);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign crc_match   = (crc_reg == win_reg[CRC_POS]);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take_byte && (fill_reg == FILL_DROP)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = preamble_ok ? ST_CRC : ST_IDLE;
            end
            ST_CRC: begin
                if (rot_reg == ROT_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        shift_in = 1'b0;
        rotate   = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                shift_in = take_byte;
            end
            ST_CHECK: begin
            end
            ST_CRC: begin
                rotate = 1'b1;
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    // The window shifts toward index 0; a full window holds the oldest byte at index 0.
    always_comb begin
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            win_next[i] = (shift_in || rotate) ? win_reg[i+1] : win_reg[i];
        end
        if (shift_in) begin
            win_next[FRAME_BYTES-1] = s_tdata;
        end else if (rotate) begin
            win_next[FRAME_BYTES-1] = win_reg[0];
        end else begin
            win_next[FRAME_BYTES-1] = win_reg[FRAME_BYTES-1];
        end
    end

    always_comb begin
        started_next = started_reg || take_byte;
        fill_next    = fill_reg;
        rot_next     = rot_reg;
        crc_next     = crc_reg;
        if (shift_in) begin
            fill_next = fill_reg + 1'b1;
        end
        if (state_reg == ST_CHECK) begin
            rot_next = '0;
            crc_next = CRC_INIT;
            if (!preamble_ok) begin
                fill_next = FILL_DROP;
            end
        end
        if (rotate) begin
            rot_next = rot_reg + 1'b1;
            if (rot_reg < CRC_STEPS) begin
                crc_next = CRC_LUT[crc_reg ^ win_reg[SEQ_HI_POS]];
            end
        end
        if (load_out) begin
            fill_next = crc_match ? '0 : FILL_DROP;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = crc_match ? STATUS_OK : STATUS_ERR;
            m_tdata_next  = {win_reg[14], crc_reg, win_reg[13],
                             win_reg[5], win_reg[6], win_reg[7], win_reg[8],
                             win_reg[9], win_reg[10], win_reg[11], win_reg[12],
                             win_reg[4], win_reg[2], win_reg[3]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            started_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            pre_first_reg  <= PREAMBLE_FIRST_RST;
            pre_second_reg <= PREAMBLE_SECOND_RST;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            started_reg  <= started_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_PREAMBLE_FIRST:  pre_first_reg  <= cfg_wr_data;
                    REG_PREAMBLE_SECOND: pre_second_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg     <= win_next;
        rot_reg     <= rot_next;
        crc_reg     <= crc_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    a_idle_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (fill_reg < FILL_FULL))
        else $error("window full while accepting bytes");

    a_crc_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CRC) |-> (fill_reg == FILL_FULL))
        else $error("CRC pass on a window that is not full");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (m_tvalid_reg && (state_reg == ST_IDLE)
                      && ((fill_reg == '0) || (fill_reg == FILL_DROP))))
        else $error("result load did not present a request or restore the window");
`endif

endmodule

### bench/fpcd_tb_pkg.sv
`timescale 1ns / 100ps

package fpcd_tb_pkg;

    localparam int         WINDOW_LEN       = 15;
    localparam logic [7:0] SYNC_FIRST_INIT  = 8'h13;
    localparam logic [7:0] SYNC_SECOND_INIT = 8'h37;
    localparam logic [7:0] LUT_OFFSET       = 8'hea;
    localparam logic [7:0] LUT_SEED         = 8'h3e;
    localparam logic [7:0] LUT_POLY         = 8'h65;
    localparam int         REPORT_LIMIT     = 10;

    // Field order is from the top bit down, so sequence_number lands in the low bits.
    typedef struct packed {
        logic        status;
        logic [7:0]  received_crc;
        logic [7:0]  computed_crc;
        logic [7:0]  final_body_byte;
        logic [63:0] body_bytes;
        logic [7:0]  packet_type;
        logic [15:0] sequence_number;
    } frame_result_t;

    // The CRC table is affine: each entry is 0xEA xor a linear image of its index,
    // so the entry is generated here rather than stored.
    function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] data);
        logic [7:0] idx;
        logic [7:0] acc;
        logic [7:0] term;
        int         k;
        idx  = crc ^ data;
        acc  = LUT_OFFSET;
        term = LUT_SEED;
        for (k = 0; k < 8; k++) begin
            if (idx[k]) begin
                acc ^= term;
            end
            term = {term[6:0], 1'b0} ^ (term[7] ? LUT_POLY : 8'h00);
        end
        return acc;
    endfunction

    class deframe_scoreboard;
        logic [7:0]    sync_first;
        logic [7:0]    sync_second;
        logic [7:0]    win [WINDOW_LEN];
        int            fill;
        bit            started;
        int            errors;
        frame_result_t pending_frames [$];

        function new();
            sync_first  = SYNC_FIRST_INIT;
            sync_second = SYNC_SECOND_INIT;
            fill        = 0;
            started     = 1'b0;
            errors      = 0;
        endfunction

        function void set_sync(logic [fpcd_pkg::CFG_ADDR_W-1:0] idx, logic [7:0] value);
            if (idx == fpcd_pkg::REG_PREAMBLE_FIRST) begin
                sync_first = value;
            end else begin
                sync_second = value;
            end
        endfunction

        function void shift_out();
            int i;
            for (i = 0; i < WINDOW_LEN - 1; i++) begin
                win[i] = win[i + 1];
            end
            fill = WINDOW_LEN - 1;
        endfunction

        function void take_byte(logic [7:0] data);
            frame_result_t r;
            logic [7:0]    crc;
            int            i;
            if (data == sync_first) begin
                started = 1'b1;
            end
            if (!started) begin
                return;
            end
            if (fill < WINDOW_LEN) begin
                win[fill] = data;
                fill++;
            end
            if (fill < WINDOW_LEN) begin
                return;
            end
            if (win[0] != sync_first || win[1] != sync_second) begin
                shift_out();
                return;
            end
            crc = 8'h00;
            for (i = 2; i < WINDOW_LEN - 1; i++) begin
                crc = crc8_next(crc, win[i]);
            end
            r.body_bytes = '0;
            for (i = 5; i <= 12; i++) begin
                r.body_bytes = {r.body_bytes[55:0], win[i]};
            end
            r.sequence_number = {win[2], win[3]};
            r.packet_type     = win[4];
            r.final_body_byte = win[13];
            r.computed_crc    = crc;
            r.received_crc    = win[WINDOW_LEN - 1];
            r.status = (crc == win[WINDOW_LEN - 1]) ? fpcd_pkg::STATUS_OK : fpcd_pkg::STATUS_ERR;
            pending_frames.push_back(r);
            if (r.status == fpcd_pkg::STATUS_OK) begin
                fill = 0;
            end else begin
                shift_out();
            end
        endfunction

        function void check_frame(logic status, logic [fpcd_pkg::TDATA_W-1:0] data);
            frame_result_t got;
            frame_result_t want;
            string         bad;
            got = {status, data};
            if (pending_frames.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("unexpected frame result: got %h", got);
                end
                return;
            end
            want = pending_frames.pop_front();
            bad  = "";
            if (got.status !== want.status) bad = {bad, " status"};
            if (got.sequence_number !== want.sequence_number) bad = {bad, " sequence_number"};
            if (got.packet_type !== want.packet_type) bad = {bad, " packet_type"};
            if (got.body_bytes !== want.body_bytes) bad = {bad, " body_bytes"};
            if (got.final_body_byte !== want.final_body_byte) bad = {bad, " final_body_byte"};
            if (got.computed_crc !== want.computed_crc) bad = {bad, " computed_crc"};
            if (got.received_crc !== want.received_crc) bad = {bad, " received_crc"};
            if (bad != "") begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("frame result mismatch in%s: expected %h, got %h", bad, want, got);
                end
            end
        endfunction

        function int pending();
            return pending_frames.size();
        endfunction
    endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import fpcd_tb_pkg::*;

    localparam int RUN_LIMIT     = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_BYTES   = 280;
    localparam int HOLD_AT_BYTE  = 700;
    localparam int HOLD_CYCLES   = 500;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_BAD_SYNC,
        FRAME_CUT,
        FRAME_EDGE
    } frame_kind_t;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [fpcd_pkg::CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [7:0]                      cfg_wr_data = '0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [fpcd_pkg::TDATA_W-1:0]    m_tdata;
    logic                            m_tuser;

    deframe_scoreboard sb = new();

    int bytes_accepted = 0;
    int cycles         = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit gaps_on        = 1'b1;

    framed_packet_crc8_deframer DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= RUN_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The receiver also owns the long hold-off that backs the block up into its input.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_frame(m_tuser, m_tdata);
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!hold_done && bytes_accepted >= HOLD_AT_BYTE) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= !(gaps_on && $urandom_range(99) < 32);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        while (gaps_on && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.take_byte(value);
        bytes_accepted++;
    endtask

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0] fr [WINDOW_LEN];
        logic [7:0] crc;
        int         n;
        int         i;
        fr[0] = sb.sync_first;
        fr[1] = sb.sync_second;
        for (i = 2; i < WINDOW_LEN - 1; i++) begin
            if (kind == FRAME_EDGE) begin
                fr[i] = i[0] ? 8'h00 : 8'hFF;
            end else begin
                case ($urandom_range(15))
                    0:       fr[i] = sb.sync_first;
                    1:       fr[i] = sb.sync_second;
                    default: fr[i] = 8'($urandom);
                endcase
            end
        end
        crc = 8'h00;
        for (i = 2; i < WINDOW_LEN - 1; i++) begin
            crc = crc8_next(crc, fr[i]);
        end
        fr[WINDOW_LEN - 1] = crc;
        n = WINDOW_LEN;
        case (kind)
            FRAME_BAD_CRC:  fr[WINDOW_LEN - 1] = crc ^ 8'($urandom_range(255, 1));
            FRAME_BAD_SYNC: fr[$urandom_range(1, 0)] ^= 8'($urandom_range(255, 1));
            FRAME_CUT:      n = $urandom_range(WINDOW_LEN - 1, 1);
            default:        ;
        endcase
        for (i = 0; i < n; i++) begin
            send_byte(fr[i]);
        end
    endtask

    task automatic send_noise(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            case ($urandom_range(7))
                0, 1:    send_byte(sb.sync_first);
                2:       send_byte(sb.sync_second);
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    task automatic run_traffic(input int count);
        int start;
        int pick;
        start = bytes_accepted;
        while (bytes_accepted - start < count) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_frame(FRAME_GOOD);
            end else if (pick < 70) begin
                send_frame(FRAME_BAD_CRC);
            end else if (pick < 76) begin
                send_frame(FRAME_BAD_SYNC);
            end else if (pick < 86) begin
                send_frame(FRAME_CUT);
            end else begin
                send_noise($urandom_range(20, 1));
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Registers change only once every request has been answered and the block has settled.
    task automatic set_preambles(input logic [7:0] first, input logic [7:0] second);
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= fpcd_pkg::REG_PREAMBLE_FIRST;
        cfg_wr_data <= first;
        @(posedge aclk);
        sb.set_sync(fpcd_pkg::REG_PREAMBLE_FIRST, first);
        cfg_addr    <= fpcd_pkg::REG_PREAMBLE_SECOND;
        cfg_wr_data <= second;
        @(posedge aclk);
        sb.set_sync(fpcd_pkg::REG_PREAMBLE_SECOND, second);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [7:0] same_sync;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sb.sync_second);
        send_frame(FRAME_EDGE);
        run_traffic(PHASE_BYTES);

        set_preambles(8'h00, 8'hFF);
        run_traffic(PHASE_BYTES);

        gaps_on = 1'b0;
        set_preambles(8'hFF, 8'h00);
        run_traffic(PHASE_BYTES);
        gaps_on = 1'b1;

        same_sync = 8'($urandom);
        set_preambles(same_sync, same_sync);
        run_traffic(PHASE_BYTES);

        set_preambles(8'($urandom), 8'($urandom));
        run_traffic(PHASE_BYTES);

        set_preambles(SYNC_FIRST_INIT, SYNC_SECOND_INIT);
        run_traffic(PHASE_BYTES);

        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/fpcd_pkg.sv
rtl/core/framed_packet_crc8_deframer.sv
bench/fpcd_tb_pkg.sv
bench/tb_top.sv
